/* rtl/core/pmc_pkg.sv */
package pmc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int SYNC_BIT = 3;
  localparam int X_OVF_BIT = 6;
  localparam int Y_OVF_BIT = 7;
  localparam int PS2_LEFT_BIT = 0;
  localparam int PS2_RIGHT_BIT = 1;

  localparam logic [7:0] REPORT_HEADER = 8'hF8;
  localparam logic signed [9:0] SAT_HIGH = 10'sd127;
  localparam logic signed [9:0] SAT_LOW = -10'sd127;

  typedef enum logic {
    OP_MOUSE_BYTE = 1'b0,
    OP_POLL       = 1'b1
  } op_t;

  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_POLL   = 1'b1
  } cmd_kind_t;

  // A completed packet or a poll, handed from the framer to the back end.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  buttons;
    logic [8:0]  dx;
    logic [8:0]  dy;
  } cmd_t;

endpackage

/* rtl/core/pmc_front.sv */
module pmc_front
  import pmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       full
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_X      = 3'b010,
    PH_Y      = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_header;
  logic [7:0] held_x_delta;
  logic       take;
  logic       header_ok;

  assign in_ready = !full;
  assign take = in_valid && !full;
  assign header_ok = in_byte[SYNC_BIT] && !in_byte[X_OVF_BIT] && !in_byte[Y_OVF_BIT];

  always_comb begin
    phase_next = phase;
    push = 1'b0;
    push_cmd.kind = CMD_POLL;
    push_cmd.buttons = {held_header[PS2_LEFT_BIT], held_header[PS2_RIGHT_BIT]};
    push_cmd.dx = {held_x_delta[7], held_x_delta};
    push_cmd.dy = 9'(-$signed({in_byte[7], in_byte}));
    if (take) begin
      if (op_t'(in_op) == OP_POLL) begin
        push = 1'b1;
      end else begin
        unique case (phase)
          PH_X: phase_next = PH_Y;
          PH_Y: begin
            phase_next = PH_HEADER;
            push = 1'b1;
            push_cmd.kind = CMD_PACKET;
          end
          default: phase_next = header_ok ? PH_X : PH_HEADER;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      held_header <= '0;
      held_x_delta <= '0;
    end else begin
      phase <= phase_next;
      if (take && op_t'(in_op) == OP_MOUSE_BYTE) begin
        if (phase == PH_X) begin
          held_x_delta <= in_byte;
        end
        if (phase != PH_X && phase != PH_Y && header_ok) begin
          held_header <= in_byte;
        end
      end
    end
  end

endmodule

/* rtl/core/pmc_queue.sv */
module pmc_queue
  import pmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pmc_back.sv */
module pmc_back
  import pmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  cmd_t       cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       report_pending;
  logic [1:0] pending_buttons;
  logic [7:0] pending_dx;
  logic [7:0] pending_dy;
  logic [1:0] remaining;
  logic [7:0] ser_header;
  logic [7:0] ser_dx;
  logic [7:0] ser_dy;
  logic       flush;

  function automatic logic [7:0] sat_add(input logic [7:0] acc, input logic [8:0] delta);
    logic signed [9:0] sum;
    sum = $signed({{2{acc[7]}}, acc}) + $signed({delta[8], delta});
    if (sum > SAT_HIGH) begin
      sum = SAT_HIGH;
    end else if (sum < SAT_LOW) begin
      sum = SAT_LOW;
    end
    return sum[7:0];
  endfunction

  assign pop = !empty && (cmd.kind == CMD_PACKET || !report_pending || remaining == '0);
  assign flush = pop && cmd.kind == CMD_POLL && report_pending;
  assign out_valid = (remaining != '0);
  assign out_last = (remaining == 2'd1);

  always_comb begin
    case (remaining)
      2'd3:    out_byte = ser_header;
      2'd2:    out_byte = ser_dx;
      default: out_byte = ser_dy;
    endcase
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      ser_header <= REPORT_HEADER | {6'b0, pending_buttons};
      ser_dx <= pending_dx;
      ser_dy <= pending_dy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_pending <= 1'b0;
      pending_buttons <= '0;
      pending_dx <= '0;
      pending_dy <= '0;
      remaining <= '0;
    end else begin
      if (flush) begin
        remaining <= 2'd3;
      end else if (out_valid && out_ready) begin
        remaining <= remaining - 1'b1;
      end
      if (pop && cmd.kind == CMD_PACKET) begin
        report_pending <= 1'b1;
        pending_buttons <= cmd.buttons;
        pending_dx <= sat_add(pending_dx, cmd.dx);
        pending_dy <= sat_add(pending_dy, cmd.dy);
      end else if (flush) begin
        report_pending <= 1'b0;
        pending_buttons <= '0;
        pending_dx <= '0;
        pending_dy <= '0;
      end
    end
  end

endmodule

/* rtl/core/ps2_mouse_packet_coalescer.sv */
// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid/s_axis_tready  tdata = mouse_byte, tuser = operation
// m_axis   out        m_axis_tvalid/m_axis_tready  tdata = report_byte, tlast = report_last
//
// An input transfer is taken in every cycle while the two-entry command queue has room.
// A completed packet is folded into the pending totals at the edge it leaves the queue.
// A poll with a packet pending loads the output register as it leaves the queue, so its first
// transfer follows the queue entry and the output register; then one transfer per ready cycle.
// A poll that finds a packet pending waits until the previous report is gone, and s_axis_tready
// drops once the queue holds two commands. Reset is synchronous and clears all control state.
module ps2_mouse_packet_coalescer
  import pmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] mouse_byte
  input  logic       s_axis_tuser,  // [0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] report_byte
  output logic       m_axis_tlast
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t pop_cmd;
  logic empty;

  pmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  pmc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  pmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .cmd       (pop_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
